// ===== sv/pulse_rate_power_meter_top_defines.svh =====
// Assertion macros shared by the pulse rate power meter checker.
`ifndef PULSE_RATE_POWER_METER_TOP_DEFINES_SVH
`define PULSE_RATE_POWER_METER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRPM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Property that holds in the cycle after reset is seen.
`define PRPM_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

// ===== sv/prpm_pkg.sv =====
// Shared types, constants and widths of the pulse rate power meter.
package prpm_pkg;

  localparam int unsigned TICKS_PER_SECOND = 1000000;
  localparam int TPS_W = $clog2(TICKS_PER_SECOND + 1);

  localparam int CNT_W      = 32;
  localparam int TIME_W     = 32;
  localparam int SCALE_W    = 32;
  localparam int PERIOD_W   = 16;
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int MPROD_W    = MUL_W + TPS_W;
  localparam int NUM_W      = PROD_W + TPS_W;
  localparam int FRAC_SHIFT = 8;
  localparam int DNUM_W     = NUM_W - FRAC_SHIFT;
  localparam int Q_W        = 48;
  localparam int DTOP_W     = DNUM_W - Q_W;
  localparam int CMP_W      = DTOP_W + TIME_W;
  localparam int STEP_W     = $clog2(Q_W);

  localparam logic [MUL_W-1:0]  TPS_WORD = MUL_W'(TICKS_PER_SECOND);
  localparam logic [Q_W-1:0]    Q_MAX    = '1;
  localparam logic [TIME_W-1:0] HOUR_DIV = TIME_W'(3600);
  localparam logic [1:0]        WARMUP_UPDATES = 2'd2;

  // The energy divisor 3600 * 2^8 equals 225 * 2^12, so the energy quotient is
  // taken in 20-bit chunks by a reciprocal multiplication for 225.
  localparam int EDIV_SHIFT   = FRAC_SHIFT + 4;
  localparam int EDIV_CHUNK_W = 20;
  localparam int EDIV_CHUNKS  = 3;
  localparam int EDIV_SRC_W   = EDIV_CHUNK_W * EDIV_CHUNKS;
  localparam int EDIV_REM_W   = 8;
  localparam int EDIV_RSHIFT  = 36;
  localparam logic [MUL_W-1:0]  EDIV_RECIP   = MUL_W'(305419897);
  localparam logic [TIME_W-1:0] EDIV_DIVISOR = TIME_W'(225);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_FIELD_W = 1 + 3 * Q_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_POWER_EDGE  = 2'd0;
  localparam opcode_t OP_SECOND_EDGE = 2'd1;
  localparam opcode_t OP_UPDATE      = 2'd2;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t CFG_MODE_PERIOD    = 3'd0;
  localparam cfg_index_t CFG_SELECT_PRESENT = 3'd1;
  localparam cfg_index_t CFG_POWER_SCALE    = 3'd2;
  localparam cfg_index_t CFG_VOLTAGE_SCALE  = 3'd3;
  localparam cfg_index_t CFG_CURRENT_SCALE  = 3'd4;

  localparam logic [PERIOD_W-1:0] RST_MODE_PERIOD    = 16'd8;
  localparam logic                RST_SELECT_PRESENT = 1'b1;
  localparam logic [SCALE_W-1:0]  RST_POWER_SCALE    = 32'd147849216;
  localparam logic [SCALE_W-1:0]  RST_VOLTAGE_SCALE  = 32'd5871026;
  localparam logic [SCALE_W-1:0]  RST_CURRENT_SCALE  = 32'd243269;
  localparam logic                RST_START_MODE     = 1'b0;

  typedef struct packed {
    logic [PERIOD_W-1:0] mode_period;
    logic                select_present;
    logic [SCALE_W-1:0]  power_scale;
    logic [SCALE_W-1:0]  voltage_scale;
    logic [SCALE_W-1:0]  current_scale;
  } cfg_t;

  typedef struct packed {
    logic              publish;
    logic              mode_bit;
    logic [CNT_W-1:0]  power_count;
    logic [CNT_W-1:0]  second_count;
    logic [TIME_W-1:0] dt;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  typedef struct packed {
    logic           published;
    logic           select_level;
    logic [Q_W-1:0] power_q16;
    logic [Q_W-1:0] second_value_q16;
    logic           value_is_current;
    logic [Q_W-1:0] energy_total_q16;
  } result_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL_P,
    BK_EDIV_MUL,
    BK_EDIV_REM,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_SUM,
    BK_DIV_LOAD,
    BK_DIV_STEP,
    BK_DIV_END,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [1:0] {
    PH_ENERGY,
    PH_POWER,
    PH_SECOND
  } phase_t;

endpackage

// ===== sv/prpm_front.sv =====
// Front end: pulse counting, mode sequencing, warmup and job creation.
module prpm_front import prpm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              item_valid,
  output logic              item_ready,
  input  opcode_t           item_opcode,
  input  logic [TIME_W-1:0] item_now,
  input  logic              queue_full,
  output q_wr_t             queue_wr
);

  logic [CNT_W-1:0]    power_count_r, power_count_nxt;
  logic [CNT_W-1:0]    second_count_r, second_count_nxt;
  logic [TIME_W-1:0]   last_time_r, last_time_nxt;
  logic                mode_bit_r, mode_bit_nxt;
  logic [PERIOD_W-1:0] mode_step_r, mode_step_nxt;
  logic [1:0]          warmup_r, warmup_nxt;

  logic                accept;
  logic                wrap;
  logic                mode_bit_upd;
  logic [PERIOD_W-1:0] mode_step_upd;

  assign item_ready = !queue_full;
  assign accept     = item_valid && item_ready;

  always_comb begin
    power_count_nxt  = power_count_r;
    second_count_nxt = second_count_r;
    last_time_nxt    = last_time_r;
    mode_bit_nxt     = mode_bit_r;
    mode_step_nxt    = mode_step_r;
    warmup_nxt       = warmup_r;

    wrap          = mode_step_r >= (cfg.mode_period - PERIOD_W'(1));
    mode_step_upd = mode_step_r;
    mode_bit_upd  = mode_bit_r;
    if (cfg.mode_period != '0) begin
      if (wrap) begin
        mode_step_upd = '0;
        if (cfg.select_present) begin
          mode_bit_upd = ~mode_bit_r;
        end
      end else begin
        mode_step_upd = mode_step_r + PERIOD_W'(1);
      end
    end

    queue_wr.push             = 1'b0;
    queue_wr.job.publish      = (mode_step_upd == '0) && (warmup_r == WARMUP_UPDATES);
    queue_wr.job.mode_bit     = mode_bit_upd;
    queue_wr.job.power_count  = power_count_r;
    queue_wr.job.second_count = second_count_r;
    queue_wr.job.dt           = item_now - last_time_r;

    if (accept) begin
      unique case (item_opcode)
        OP_POWER_EDGE: begin
          power_count_nxt = power_count_r + CNT_W'(1);
        end
        OP_SECOND_EDGE: begin
          second_count_nxt = second_count_r + CNT_W'(1);
        end
        OP_UPDATE: begin
          queue_wr.push    = 1'b1;
          power_count_nxt  = '0;
          second_count_nxt = '0;
          last_time_nxt    = item_now;
          mode_bit_nxt     = mode_bit_upd;
          mode_step_nxt    = mode_step_upd;
          if ((mode_step_upd == '0) && (warmup_r != WARMUP_UPDATES)) begin
            warmup_nxt = warmup_r + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_count_r  <= '0;
      second_count_r <= '0;
      last_time_r    <= '0;
      mode_bit_r     <= RST_START_MODE;
      mode_step_r    <= '0;
      warmup_r       <= '0;
    end else begin
      power_count_r  <= power_count_nxt;
      second_count_r <= second_count_nxt;
      last_time_r    <= last_time_nxt;
      mode_bit_r     <= mode_bit_nxt;
      mode_step_r    <= mode_step_nxt;
      warmup_r       <= warmup_nxt;
    end
  end

endmodule

// ===== sv/prpm_queue.sv =====
// Short job queue between the front end and the arithmetic back end.
module prpm_queue import prpm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t wr,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output job_t  head
);

  job_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = count_r == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = entry_r[rd_ptr_r];
  assign do_push   = wr.push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== sv/prpm_back.sv =====
// Back end: shared multiplier and radix-2 divider, energy total and result register.
module prpm_back import prpm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    job_valid,
  output logic    job_pop,
  input  job_t    job,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  bk_state_t            state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  job_t                 job_r, job_nxt;
  logic [PROD_W-1:0]    p_r, p_nxt;
  logic [MPROD_W-1:0]   mlo_r, mlo_nxt;
  logic [MPROD_W-1:0]   mhi_r, mhi_nxt;
  logic [NUM_W-1:0]     n_r, n_nxt;
  logic [TIME_W-1:0]    rem_r, rem_nxt;
  logic [TIME_W-1:0]    div_r, div_nxt;
  logic [Q_W-1:0]       low_r, low_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [Q_W-1:0]       pw_r, pw_nxt;
  logic [Q_W-1:0]       sv_r, sv_nxt;
  logic [Q_W-1:0]       energy_r, energy_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_r, out_nxt;

  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic [DNUM_W-1:0]    div_num;
  logic [TIME_W-1:0]    div_den;
  logic [DTOP_W-1:0]    div_top;
  logic [TIME_W:0]      trial;
  logic [TIME_W:0]      diff;
  logic                 ge;
  logic [MUL_W-1:0]     ediv_t;

  assign mul_p     = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    job_nxt       = job_r;
    p_nxt         = p_r;
    mlo_nxt       = mlo_r;
    mhi_nxt       = mhi_r;
    n_nxt         = n_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    low_nxt       = low_r;
    step_nxt      = step_r;
    pw_nxt        = pw_r;
    sv_nxt        = sv_r;
    energy_nxt    = energy_r;
    out_valid_nxt = out_valid_r && !res_ready;
    out_nxt       = out_r;
    job_pop       = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    div_num = n_r[NUM_W-1:FRAC_SHIFT];
    div_den = job_r.dt;
    div_top = div_num[DNUM_W-1:Q_W];
    trial   = {rem_r, low_r[Q_W-1]};
    diff    = trial - {1'b0, div_r};
    ge      = trial >= {1'b0, div_r};
    ediv_t  = MUL_W'({rem_r[EDIV_REM_W-1:0], n_r[EDIV_SRC_W-1 -: EDIV_CHUNK_W]});

    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          job_nxt   = job;
          phase_nxt = PH_ENERGY;
          state_nxt = job.publish ? BK_MUL_P : BK_EMIT;
        end
      end
      BK_MUL_P: begin
        if (phase_r == PH_SECOND) begin
          mul_a = job_r.second_count;
          mul_b = job_r.mode_bit ? cfg.current_scale : cfg.voltage_scale;
        end else begin
          mul_a = job_r.power_count;
          mul_b = cfg.power_scale;
        end
        p_nxt = mul_p;
        if (phase_r == PH_ENERGY) begin
          n_nxt     = NUM_W'(mul_p >> EDIV_SHIFT);
          rem_nxt   = '0;
          low_nxt   = '0;
          step_nxt  = '0;
          state_nxt = BK_EDIV_MUL;
        end else begin
          state_nxt = BK_MUL_LO;
        end
      end
      BK_EDIV_MUL: begin
        mul_a     = ediv_t;
        mul_b     = EDIV_RECIP;
        div_nxt   = TIME_W'(mul_p >> EDIV_RSHIFT);
        rem_nxt   = ediv_t;
        state_nxt = BK_EDIV_REM;
      end
      BK_EDIV_REM: begin
        rem_nxt  = rem_r - div_r * EDIV_DIVISOR;
        low_nxt  = {low_r[Q_W-EDIV_CHUNK_W-1:0], div_r[EDIV_CHUNK_W-1:0]};
        n_nxt    = n_r << EDIV_CHUNK_W;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(EDIV_CHUNKS - 1)) begin
          state_nxt = BK_DIV_END;
        end else begin
          state_nxt = BK_EDIV_MUL;
        end
      end
      BK_MUL_LO: begin
        mul_a     = p_r[MUL_W-1:0];
        mul_b     = TPS_WORD;
        mlo_nxt   = mul_p[MPROD_W-1:0];
        state_nxt = BK_MUL_HI;
      end
      BK_MUL_HI: begin
        mul_a     = p_r[PROD_W-1:MUL_W];
        mul_b     = TPS_WORD;
        mhi_nxt   = mul_p[MPROD_W-1:0];
        state_nxt = BK_SUM;
      end
      BK_SUM: begin
        n_nxt     = NUM_W'(mlo_r) + (NUM_W'(mhi_r) << MUL_W);
        state_nxt = BK_DIV_LOAD;
      end
      BK_DIV_LOAD: begin
        div_nxt  = div_den;
        step_nxt = '0;
        if (div_den == '0) begin
          low_nxt   = '0;
          state_nxt = BK_DIV_END;
        end else if (CMP_W'(div_top) >= CMP_W'(div_den)) begin
          low_nxt   = Q_MAX;
          state_nxt = BK_DIV_END;
        end else begin
          rem_nxt   = TIME_W'(div_top);
          low_nxt   = div_num[Q_W-1:0];
          state_nxt = BK_DIV_STEP;
        end
      end
      BK_DIV_STEP: begin
        rem_nxt  = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
        low_nxt  = {low_r[Q_W-2:0], ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(Q_W - 1)) begin
          state_nxt = BK_DIV_END;
        end
      end
      BK_DIV_END: begin
        unique case (phase_r)
          PH_ENERGY: begin
            if (low_r >= (Q_MAX - energy_r)) begin
              energy_nxt = Q_MAX;
            end else begin
              energy_nxt = energy_r + low_r;
            end
            phase_nxt = PH_POWER;
            state_nxt = BK_MUL_P;
          end
          PH_POWER: begin
            pw_nxt    = low_r;
            phase_nxt = PH_SECOND;
            state_nxt = BK_MUL_P;
          end
          PH_SECOND: begin
            sv_nxt    = low_r;
            state_nxt = BK_EMIT;
          end
          default: begin
            state_nxt = BK_IDLE;
          end
        endcase
      end
      BK_EMIT: begin
        if (!out_valid_r || res_ready) begin
          out_valid_nxt            = 1'b1;
          out_nxt.published        = job_r.publish;
          out_nxt.select_level     = job_r.mode_bit;
          out_nxt.power_q16        = job_r.publish ? pw_r : '0;
          out_nxt.second_value_q16 = job_r.publish ? sv_r : '0;
          out_nxt.value_is_current = job_r.publish && job_r.mode_bit;
          out_nxt.energy_total_q16 = job_r.publish ? energy_r : '0;
          state_nxt                = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    p_r    <= p_nxt;
    mlo_r  <= mlo_nxt;
    mhi_r  <= mhi_nxt;
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    low_r  <= low_nxt;
    step_r <= step_nxt;
    pw_r   <= pw_nxt;
    sv_r   <= sv_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      phase_r     <= PH_ENERGY;
      energy_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      energy_r    <= energy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/pulse_rate_power_meter_top.sv =====
// Top level of the pulse rate power meter: configuration registers and the three parts.
//
//  Channel   Direction  Handshake                  Contents
//  in_*      slave      in_tvalid / in_tready      edge or update request, timestamp
//  out_*     master     out_tvalid / out_tready    one result request per update
//  cfg_*     slave      cfg_valid / cfg_ready      register index and write data
//
// Edge requests never wait on the back end unless the two-entry job queue is
// full. A published update passes through the one shared divider twice, once
// for power and once for the second value, 48 steps per pass; an unpublished
// update skips the arithmetic. Reset is synchronous.
// A stalled result is held in the output register while new requests are taken.
module pulse_rate_power_meter_top import prpm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] now_us
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [1:0] opcode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] select_level, [48:1] power_q16,
                                             // [96:49] second_value_q16,
                                             // [144:97] energy_total_q16, rest zero
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [0] published, [1] value_is_current
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg_r, cfg_nxt;
  q_wr_t   queue_wr;
  logic    queue_full;
  logic    queue_not_empty;
  logic    job_pop;
  job_t    queue_head;
  result_t result;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE_PERIOD:    cfg_nxt.mode_period    = cfg_data[PERIOD_W-1:0];
        CFG_SELECT_PRESENT: cfg_nxt.select_present = cfg_data[0];
        CFG_POWER_SCALE:    cfg_nxt.power_scale    = cfg_data[SCALE_W-1:0];
        CFG_VOLTAGE_SCALE:  cfg_nxt.voltage_scale  = cfg_data[SCALE_W-1:0];
        CFG_CURRENT_SCALE:  cfg_nxt.current_scale  = cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_period    <= RST_MODE_PERIOD;
      cfg_r.select_present <= RST_SELECT_PRESENT;
      cfg_r.power_scale    <= RST_POWER_SCALE;
      cfg_r.voltage_scale  <= RST_VOLTAGE_SCALE;
      cfg_r.current_scale  <= RST_CURRENT_SCALE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  prpm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .item_valid  (in_tvalid),
    .item_ready  (in_tready),
    .item_opcode (in_tuser),
    .item_now    (in_tdata[TIME_W-1:0]),
    .queue_full  (queue_full),
    .queue_wr    (queue_wr)
  );

  prpm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (queue_wr),
    .full      (queue_full),
    .pop       (job_pop),
    .not_empty (queue_not_empty),
    .head      (queue_head)
  );

  prpm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (queue_not_empty),
    .job_pop   (job_pop),
    .job       (queue_head),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (result)
  );

  assign out_tdata = OUT_TDATA_W'({result.energy_total_q16, result.second_value_q16,
                                   result.power_q16, result.select_level});
  assign out_tuser = {result.value_is_current, result.published};

endmodule

// ===== sv/prpm_checker.sv =====
// Port-level assertion checker for the pulse rate power meter, bound to the top level.
`include "pulse_rate_power_meter_top_defines.svh"

module prpm_checker import prpm_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  `PRPM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `PRPM_ASSERT_SAME(a_unpub_zero, out_tvalid && !out_tuser[0], (out_tdata[OUT_TDATA_W-1:1] == '0) && !out_tuser[1], "unpublished result carries data")
  `PRPM_ASSERT_SAME(a_kind_match, out_tvalid && out_tuser[0], out_tuser[1] == out_tdata[0], "value kind differs from select level")
  `PRPM_ASSERT_RESET(a_reset_idle, !out_tvalid && in_tready, "not idle after reset")

endmodule

bind pulse_rate_power_meter_top prpm_checker u_prpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
